### rtl/core/decision_tree_classify_importance_defines.svh
// assertion macros shared by the decision tree classifier rtl
`ifndef DECISION_TREE_CLASSIFY_IMPORTANCE_DEFINES_SVH
`define DECISION_TREE_CLASSIFY_IMPORTANCE_DEFINES_SVH

// plain check, sampled on clk_i, off while in reset
`define DTCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication check, consequent sampled in the next cycle
`define DTCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dtci_pkg.sv
// types and constants of the decision tree classifier
package dtci_pkg;

  localparam int unsigned NumNodes   = 1024;
  localparam int unsigned NumFeat    = 64;
  localparam int unsigned NodeAw     = 10;
  localparam int unsigned FeatAw     = 6;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned TotalW     = 48;
  localparam int unsigned LimitW     = 11;
  localparam int unsigned ClassW     = 8;
  localparam logic [LimitW-1:0] LimitReset = 11'd1024;

  typedef enum logic [1:0] {
    OP_WR_NODE  = 2'd0,
    OP_WR_FEAT  = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_RD_IMP   = 2'd3
  } op_e;

  localparam logic KindClass = 1'b0;
  localparam logic KindImp   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_NODE,
    S_UPDATE,
    S_DONE
  } state_e;

  // one tree node as held in the node memory
  typedef struct packed {
    logic              terminal;
    logic [FeatAw-1:0] split_var;
    logic [ValueW-1:0] threshold;
    logic [NodeAw-1:0] left;
    logic [NodeAw-1:0] right;
    logic [ClassW-1:0] label;
    logic [ValueW-1:0] gain;
  } node_t;

  // input tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]        pad;
    logic              in_bag;
    logic [ValueW-1:0] feature_value;
    logic [FeatAw-1:0] feature_index;
    logic [ValueW-1:0] gini_decrease;
    logic [ClassW-1:0] node_class;
    logic [NodeAw-1:0] right_child;
    logic [NodeAw-1:0] left_child;
    logic [ValueW-1:0] split_threshold;
    logic [FeatAw-1:0] split_var;
    logic              node_terminal;
    logic [NodeAw-1:0] node_index;
  } in_data_t;

  // output tdata layout, lowest field last
  typedef struct packed {
    logic [4:0]        pad;
    logic [TotalW-1:0] oob_importance;
    logic [TotalW-1:0] inbag_importance;
    logic              found_leaf;
    logic [NodeAw-1:0] leaf_node;
    logic [ClassW-1:0] pred_class;
  } out_data_t;

  // in-bag total in the low half, out-of-bag total in the high half
  typedef struct packed {
    logic [TotalW-1:0] oob;
    logic [TotalW-1:0] inbag;
  } totals_t;

endpackage

### rtl/core/dtci_ram.sv
// generic single write port ram with registered read
module dtci_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/decision_tree_classify_importance.sv
// decision tree classifier with split gain importance totals, top level
//
// One item is taken at a time. Node and feature writes complete as they are
// accepted. An importance read fetches the totals row, then loads it into the
// output register once that is free. A classify walk ends on a leaf or when the
// walk limit stops it; each step is a read of the node memory, then a read of
// the feature and totals memories, then a compare and a saturating
// read-modify-write of the totals row, and the next item waits until the walk
// ends. The totals memory is marked clear at reset by one valid bit per
// variable, so no clearing pass is needed. A finished result waits in the output
// register while the next item is accepted.
module decision_tree_classify_importance
  import dtci_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // config: walk_limit
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // node_index, node_terminal, split_var, split_threshold, left_child,
  // right_child, node_class, gini_decrease, feature_index, feature_value, in_bag
  input  logic [151:0]      s_axis_tdata,
  // opcode
  input  logic [1:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // pred_class, leaf_node, found_leaf, inbag_importance, oob_importance
  output logic [119:0]      m_axis_tdata,
  // result_kind
  output logic [0:0]        m_axis_tuser
);

  `include "decision_tree_classify_importance_defines.svh"

  state_e            state_q, state_d;
  in_data_t          in_data;
  op_e               in_op;
  logic              in_acc;

  logic [LimitW-1:0] walk_limit_q;
  logic [NodeAw-1:0] kt_q, kt_d;
  logic [LimitW-1:0] walk_cnt_q, walk_cnt_d;
  logic              inb_q, inb_d;
  logic              kind_q, kind_d;
  logic              found_q, found_d;
  logic [ClassW-1:0] class_q, class_d;
  logic [NodeAw-1:0] leaf_q, leaf_d;

  logic [NumFeat-1:0] tot_valid_q;
  logic               tot_vld_rd_q;

  node_t              node_rd, node_wr;
  logic               node_re;
  logic [ValueW-1:0]  feat_rd;
  logic               feat_re;
  totals_t            tot_rd, tot_cur, tot_wr;
  logic               tot_re, tot_we;
  logic [FeatAw-1:0]  tot_raddr;

  logic [TotalW:0]    sum;
  logic [TotalW-1:0]  sat_sum;
  logic               go_left;

  logic               m_valid_q, m_valid_d;
  out_data_t          m_data_q, m_data_d;
  logic               m_kind_q, m_kind_d;
  logic               out_load;

  assign in_data = in_data_t'(s_axis_tdata);
  assign in_op   = op_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign node_wr = '{
    terminal:  in_data.node_terminal,
    split_var: in_data.split_var,
    threshold: in_data.split_threshold,
    left:      in_data.left_child,
    right:     in_data.right_child,
    label:     in_data.node_class,
    gain:      in_data.gini_decrease
  };

  dtci_ram #(.DataW($bits(node_t)), .Depth(NumNodes)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_op == OP_WR_NODE)),
    .waddr_i (in_data.node_index),
    .wdata_i (node_wr),
    .re_i    (node_re),
    .raddr_i (kt_q),
    .rdata_o (node_rd)
  );

  dtci_ram #(.DataW(ValueW), .Depth(NumFeat)) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_op == OP_WR_FEAT)),
    .waddr_i (in_data.feature_index),
    .wdata_i (in_data.feature_value),
    .re_i    (feat_re),
    .raddr_i (node_rd.split_var),
    .rdata_o (feat_rd)
  );

  dtci_ram #(.DataW($bits(totals_t)), .Depth(NumFeat)) u_tot_ram (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (node_rd.split_var),
    .wdata_i (tot_wr),
    .re_i    (tot_re),
    .raddr_i (tot_raddr),
    .rdata_o (tot_rd)
  );

  // a row never written reads as zero
  assign tot_cur = tot_vld_rd_q ? tot_rd : '0;

  // saturating add of the node gain to the selected total
  assign sum     = {1'b0, (inb_q ? tot_cur.inbag : tot_cur.oob)}
                 + {{(TotalW + 1 - ValueW){1'b0}}, node_rd.gain};
  assign sat_sum = sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];

  always_comb begin
    tot_wr = tot_cur;
    if (inb_q) begin
      tot_wr.inbag = sat_sum;
    end else begin
      tot_wr.oob = sat_sum;
    end
  end

  assign go_left = $signed(node_rd.threshold) > $signed(feat_rd);

  always_comb begin
    state_d    = state_q;
    kt_d       = kt_q;
    walk_cnt_d = walk_cnt_q;
    inb_d      = inb_q;
    kind_d     = kind_q;
    found_d    = found_q;
    class_d    = class_q;
    leaf_d     = leaf_q;
    node_re    = 1'b0;
    feat_re    = 1'b0;
    tot_re     = 1'b0;
    tot_we     = 1'b0;
    tot_raddr  = node_rd.split_var;
    out_load   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        tot_raddr = in_data.feature_index;
        if (in_acc) begin
          unique case (in_op)
            OP_CLASSIFY: begin
              kt_d       = '0;
              walk_cnt_d = '0;
              inb_d      = in_data.in_bag;
              kind_d     = KindClass;
              state_d    = S_FETCH;
            end
            OP_RD_IMP: begin
              tot_re  = 1'b1;
              kind_d  = KindImp;
              found_d = 1'b0;
              class_d = '0;
              leaf_d  = '0;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (walk_cnt_q >= walk_limit_q) begin
          found_d = 1'b0;
          class_d = '0;
          leaf_d  = '0;
          state_d = S_DONE;
        end else begin
          node_re = 1'b1;
          state_d = S_NODE;
        end
      end
      S_NODE: begin
        if (node_rd.terminal) begin
          found_d = 1'b1;
          class_d = node_rd.label;
          leaf_d  = kt_q;
          state_d = S_DONE;
        end else begin
          feat_re = 1'b1;
          tot_re  = 1'b1;
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        tot_we     = 1'b1;
        kt_d       = go_left ? node_rd.left : node_rd.right;
        walk_cnt_d = walk_cnt_q + 1'b1;
        state_d    = S_FETCH;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_data_d  = m_data_q;
    m_kind_d  = m_kind_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    if (out_load) begin
      m_valid_d                 = 1'b1;
      m_kind_d                  = kind_q;
      m_data_d.pad              = '0;
      m_data_d.pred_class       = class_q;
      m_data_d.leaf_node        = leaf_q;
      m_data_d.found_leaf       = found_q;
      m_data_d.inbag_importance = (kind_q == KindImp) ? tot_cur.inbag : '0;
      m_data_d.oob_importance   = (kind_q == KindImp) ? tot_cur.oob : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      walk_limit_q <= LimitReset;
      tot_valid_q  <= '0;
      m_valid_q    <= 1'b0;
      kt_q         <= '0;
      walk_cnt_q   <= '0;
    end else begin
      state_q    <= state_d;
      m_valid_q  <= m_valid_d;
      kt_q       <= kt_d;
      walk_cnt_q <= walk_cnt_d;
      if (cfg_we_i) begin
        walk_limit_q <= cfg_wdata_i;
      end
      if (tot_we) begin
        tot_valid_q[node_rd.split_var] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    inb_q    <= inb_d;
    kind_q   <= kind_d;
    found_q  <= found_d;
    class_q  <= class_d;
    leaf_q   <= leaf_d;
    m_data_q <= m_data_d;
    m_kind_q <= m_kind_d;
    if (tot_re) begin
      tot_vld_rd_q <= tot_valid_q[tot_raddr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;

  `DTCI_ASSERT_NEXT(a_walk_step_count, state_q == S_UPDATE,
                    walk_cnt_q == $past(walk_cnt_q) + 11'd1, "walk count did not advance")
  `DTCI_ASSERT_NEXT(a_tot_row_marked, tot_we,
                    tot_valid_q[$past(node_rd.split_var)], "written totals row not marked")
  `DTCI_ASSERT(a_load_in_done, $rose(m_valid_q) |-> $past(state_q == S_DONE),
               "result loaded outside done")
  `DTCI_ASSERT_NEXT(a_fetch_reads_node,
                    (state_q == S_FETCH) && (walk_cnt_q < walk_limit_q),
                    state_q == S_NODE, "node fetch did not read node memory")
  `DTCI_ASSERT(a_imp_fields_zero, m_valid_q && (m_kind_q == KindImp) |-> !m_data_q.found_leaf
               && (m_data_q.leaf_node == '0) && (m_data_q.pred_class == '0),
               "importance result carries classify fields")

endmodule
